// ===== rtl/acs_pkg.sv =====
// acs_pkg: shared types and constants of the annex b codec sniffer
package acs_pkg;

  // codec codes as reported on the result word
  typedef enum logic [1:0] {
    CODEC_AVC  = 2'd0,
    CODEC_HEVC = 2'd1,
    CODEC_NONE = 2'd2
  } codec_t;

  // register and queue defaults
  localparam logic [7:0] NAL_LIMIT_RESET = 8'd100;
  localparam int         QUEUE_DEPTH     = 2;

  // start code bytes
  localparam logic [7:0] SC_ZERO = 8'h00;
  localparam logic [7:0] SC_ONE  = 8'h01;

  // avc nal unit types that settle the codec
  localparam logic [4:0] AVC_IDR = 5'd5;
  localparam logic [4:0] AVC_SPS = 5'd7;
  localparam logic [4:0] AVC_PPS = 5'd8;
  localparam logic [4:0] AVC_AUD = 5'd9;

  // hevc nal unit types that settle the codec
  localparam logic [5:0] HEVC_IDR_W_RADL = 6'd19;
  localparam logic [5:0] HEVC_IDR_N_LP   = 6'd20;
  localparam logic [5:0] HEVC_VPS        = 6'd32;
  localparam logic [5:0] HEVC_SPS        = 6'd33;
  localparam logic [5:0] HEVC_PPS        = 6'd34;
  localparam logic [5:0] HEVC_AUD        = 6'd35;

  // classified stream byte passed from front to back
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       is_zero;
    logic       is_one;
    logic       avc_hit;
    logic       hevc_hit;
  } word_t;

endpackage

// ===== rtl/annexb_codec_sniffer.sv =====
// annexb_codec_sniffer: top level of the annex b start code and nal header sniffer
//
// Input channel in_valid/in_ready carries one stream byte per word (in_byte)
// with last_byte marking the final byte of a buffer. For each buffer one
// result word leaves on out_valid/out_ready after its last byte: codec,
// nal_seen, limit_hit, info_valid and the first nal header fields.
// The cfg_valid/cfg_ready port writes nal_limit (reset 100); cfg_ready is
// always high, and writes are meant only while the block is idle.
// A byte passes the classifier into a two-entry queue and is scanned as it
// leaves the queue; the result register loads at the edge that pops the
// last byte. Throughput is one byte per cycle while the queue has room
// and no held result blocks a last byte.
// When the receiver stalls, the held result blocks only the next last byte;
// ordinary bytes keep flowing until the queue fills, then in_ready drops.
// Reset empties the queue, drops any pending result, clears the scan state
// and restores nal_limit to 100. After each result the scanner restarts
// for the next buffer.
module annexb_codec_sniffer #(
  parameter int QUEUE_DEPTH = acs_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       last_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] codec,
  output logic [7:0] nal_seen,
  output logic       limit_hit,
  output logic       info_valid,
  output logic [1:0] ref_idc,
  output logic [5:0] layer_id,
  output logic [2:0] temporal_id_plus1,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data
);

  logic [7:0]     nal_limit;
  logic           push_valid;
  logic           push_ready;
  acs_pkg::word_t push_word;
  logic           pop_valid;
  logic           pop_ready;
  acs_pkg::word_t pop_word;

  // limit register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      nal_limit <= acs_pkg::NAL_LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      nal_limit <= cfg_data;
    end
  end

  // byte classifier
  acs_front u_front (
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_byte    (in_byte),
    .last_byte  (last_byte),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_word  (push_word)
  );

  // decoupling queue
  acs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_word  (push_word),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_word   (pop_word)
  );

  // scanner and result register
  acs_back u_back (
    .clk               (clk),
    .rst               (rst),
    .nal_limit         (nal_limit),
    .pop_valid         (pop_valid),
    .pop_ready         (pop_ready),
    .pop_word          (pop_word),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .codec             (codec),
    .nal_seen          (nal_seen),
    .limit_hit         (limit_hit),
    .info_valid        (info_valid),
    .ref_idc           (ref_idc),
    .layer_id          (layer_id),
    .temporal_id_plus1 (temporal_id_plus1)
  );

endmodule

// ===== rtl/acs_front.sv =====
// acs_front: accepts stream bytes and classifies them for the scanner
module acs_front (
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [7:0]     in_byte,
  input  logic           last_byte,
  output logic           push_valid,
  input  logic           push_ready,
  output acs_pkg::word_t push_word
);

  logic [4:0] avc_type;
  logic [5:0] hevc_type;

  // nal type fields as both codecs would read the byte
  assign avc_type  = in_byte[4:0];
  assign hevc_type = in_byte[6:1];

  // classification of the incoming word
  always_comb begin
    push_word.data     = in_byte;
    push_word.last     = last_byte;
    push_word.is_zero  = (in_byte == acs_pkg::SC_ZERO);
    push_word.is_one   = (in_byte == acs_pkg::SC_ONE);
    push_word.avc_hit  = (avc_type == acs_pkg::AVC_SPS) || (avc_type == acs_pkg::AVC_PPS) ||
                         (avc_type == acs_pkg::AVC_IDR) || (avc_type == acs_pkg::AVC_AUD);
    push_word.hevc_hit = (hevc_type == acs_pkg::HEVC_VPS) ||
                         (hevc_type == acs_pkg::HEVC_SPS) ||
                         (hevc_type == acs_pkg::HEVC_PPS) ||
                         (hevc_type == acs_pkg::HEVC_AUD) ||
                         (hevc_type == acs_pkg::HEVC_IDR_W_RADL) ||
                         (hevc_type == acs_pkg::HEVC_IDR_N_LP);
  end

  // handshake passes straight to the queue
  assign push_valid = in_valid;
  assign in_ready   = push_ready;

endmodule

// ===== rtl/acs_queue.sv =====
// acs_queue: short fifo of classified words between front and back
module acs_queue #(
  parameter int DEPTH = acs_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  acs_pkg::word_t push_word,
  output logic           pop_valid,
  input  logic           pop_ready,
  output acs_pkg::word_t pop_word
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  acs_pkg::word_t   mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign push_ready = (count != FULL_CNT);
  assign pop_valid  = (count != '0);
  assign pop_word   = mem[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_word;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/acs_back.sv =====
// acs_back: start code scanner, codec decision and result register
module acs_back (
  input  logic           clk,
  input  logic           rst,
  input  logic [7:0]     nal_limit,
  input  logic           pop_valid,
  output logic           pop_ready,
  input  acs_pkg::word_t pop_word,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [1:0]     codec,
  output logic [7:0]     nal_seen,
  output logic           limit_hit,
  output logic           info_valid,
  output logic [1:0]     ref_idc,
  output logic [5:0]     layer_id,
  output logic [2:0]     temporal_id_plus1
);

  typedef enum logic [1:0] {
    PH_NONE  = 2'd0,
    PH_FIRST = 2'd1,
    PH_BOTH  = 2'd2
  } phase_t;

  // scan state
  logic             [1:0] zero_run;
  logic                   header_next;
  logic             [7:0] header_count;
  logic                   scan_done;
  acs_pkg::codec_t        decided_codec;
  logic             [7:0] first_header;
  logic             [7:0] second_header;
  phase_t                 first_phase;

  // next values after the current word
  logic             [1:0] zero_run_next;
  logic                   header_next_next;
  logic             [7:0] header_count_next;
  logic                   scan_done_next;
  acs_pkg::codec_t        decided_codec_next;
  logic             [7:0] first_header_next;
  logic             [7:0] second_header_next;
  phase_t                 first_phase_next;

  // result built from the next values
  acs_pkg::codec_t        res_codec;
  logic                   res_limit;
  logic                   res_info;
  logic             [1:0] res_ridc;
  logic             [5:0] res_lid;
  logic             [2:0] res_tid;

  logic                   pop;

  // a last word needs a free result register, other words go through
  assign pop_ready = !pop_word.last || !out_valid || out_ready;
  assign pop       = pop_valid && pop_ready;

  // scanner update for one word
  always_comb begin
    zero_run_next      = zero_run;
    header_next_next   = header_next;
    header_count_next  = header_count;
    scan_done_next     = scan_done;
    decided_codec_next = decided_codec;
    first_header_next  = first_header;
    second_header_next = second_header;
    first_phase_next   = first_phase;

    // byte after the first header is kept even once decided
    if (first_phase == PH_FIRST) begin
      second_header_next = pop_word.data;
      first_phase_next   = PH_BOTH;
    end

    if (!scan_done) begin
      if (header_next) begin
        header_next_next  = 1'b0;
        zero_run_next     = 2'd0;
        header_count_next = header_count + 8'd1;
        if (first_phase == PH_NONE) begin
          first_header_next = pop_word.data;
          first_phase_next  = PH_FIRST;
        end
        if (pop_word.avc_hit) begin
          decided_codec_next = acs_pkg::CODEC_AVC;
          scan_done_next     = 1'b1;
        end else if (pop_word.hevc_hit) begin
          decided_codec_next = acs_pkg::CODEC_HEVC;
          scan_done_next     = 1'b1;
        end else if (header_count_next >= nal_limit) begin
          scan_done_next = 1'b1;
        end
      end else if ((zero_run == 2'd2) && pop_word.is_one) begin
        header_next_next = 1'b1;
        zero_run_next    = 2'd0;
      end else if (pop_word.is_zero) begin
        if (zero_run != 2'd2) begin
          zero_run_next = zero_run + 2'd1;
        end
      end else begin
        zero_run_next = 2'd0;
      end
    end
  end

  // result fields
  always_comb begin
    res_codec = scan_done_next ? decided_codec_next : acs_pkg::CODEC_NONE;
    res_limit = scan_done_next && (decided_codec_next == acs_pkg::CODEC_NONE);
    res_info  = 1'b0;
    res_ridc  = 2'd0;
    res_lid   = 6'd0;
    res_tid   = 3'd0;
    if ((res_codec == acs_pkg::CODEC_AVC) && (first_phase_next != PH_NONE)) begin
      res_info = 1'b1;
      res_ridc = first_header_next[6:5];
    end else if ((res_codec == acs_pkg::CODEC_HEVC) && (first_phase_next == PH_BOTH)) begin
      res_info = 1'b1;
      res_lid  = {first_header_next[0], second_header_next[7:3]};
      res_tid  = second_header_next[2:0];
    end
  end

  // scan state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      zero_run      <= 2'd0;
      header_next   <= 1'b0;
      header_count  <= 8'd0;
      scan_done     <= 1'b0;
      decided_codec <= acs_pkg::CODEC_NONE;
      first_header  <= 8'd0;
      second_header <= 8'd0;
      first_phase   <= PH_NONE;
      out_valid     <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (pop) begin
        if (pop_word.last) begin
          // result out, scanner back to its start
          out_valid         <= 1'b1;
          codec             <= res_codec;
          nal_seen          <= header_count_next;
          limit_hit         <= res_limit;
          info_valid        <= res_info;
          ref_idc           <= res_ridc;
          layer_id          <= res_lid;
          temporal_id_plus1 <= res_tid;
          zero_run          <= 2'd0;
          header_next       <= 1'b0;
          header_count      <= 8'd0;
          scan_done         <= 1'b0;
          decided_codec     <= acs_pkg::CODEC_NONE;
          first_header      <= 8'd0;
          second_header     <= 8'd0;
          first_phase       <= PH_NONE;
        end else begin
          zero_run      <= zero_run_next;
          header_next   <= header_next_next;
          header_count  <= header_count_next;
          scan_done     <= scan_done_next;
          decided_codec <= decided_codec_next;
          first_header  <= first_header_next;
          second_header <= second_header_next;
          first_phase   <= first_phase_next;
        end
      end
    end
  end

`ifndef SYNTHESIS
  // zero run saturates at two
  assert property (@(posedge clk) disable iff (rst) zero_run != 2'd3)
    else $error("zero run above saturation");

  // a pending header never coexists with a finished scan
  assert property (@(posedge clk) disable iff (rst) scan_done |-> !header_next)
    else $error("header pending after decision");

  // an unrecognized result carries no header info
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (codec == acs_pkg::CODEC_NONE) |-> !info_valid)
    else $error("info on unrecognized result");

  // limit only reported without a codec
  assert property (@(posedge clk) disable iff (rst)
    out_valid && limit_hit |-> (codec == acs_pkg::CODEC_NONE))
    else $error("limit hit with decided codec");

  // a consumed last word always shows a result next cycle
  assert property (@(posedge clk) disable iff (rst)
    pop && pop_word.last |=> out_valid && (first_phase == PH_NONE))
    else $error("last word left no result");
`endif

endmodule
